// ----- src/tli_pkg.sv -----
package tli_pkg;

    localparam int PROG_DEPTH = 65536;
    localparam int TAPE_DEPTH = 32768;
    localparam int NEST_DEPTH = 256;

    localparam int PROG_AW = $clog2(PROG_DEPTH);
    localparam int PROG_LW = PROG_AW + 1;
    localparam int PROG_EW = 3 + PROG_AW;
    localparam int TAPE_AW = $clog2(TAPE_DEPTH);
    localparam int NEST_AW = $clog2(NEST_DEPTH);
    localparam int NEST_LW = NEST_AW + 1;

    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    localparam logic [2:0] OP_RIGHT = 3'd0;
    localparam logic [2:0] OP_LEFT  = 3'd1;
    localparam logic [2:0] OP_INC   = 3'd2;
    localparam logic [2:0] OP_DEC   = 3'd3;
    localparam logic [2:0] OP_OUT   = 3'd4;
    localparam logic [2:0] OP_IN    = 3'd5;
    localparam logic [2:0] OP_OPEN  = 3'd6;
    localparam logic [2:0] OP_CLOSE = 3'd7;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BRACKET = 2'd1;
    localparam logic [1:0] ERR_TAPE    = 2'd2;
    localparam logic [1:0] ERR_FULL    = 2'd3;

    typedef struct packed {
        logic       is_cmd;
        logic [2:0] op;
    } t_decode;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       in_consumed;
        logic       need_input;
        logic       halted;
        logic [1:0] error_code;
    } t_result;

    function automatic t_decode decode_symbol(input logic [7:0] sym);
        t_decode d;
        d.is_cmd = 1'b1;
        d.op     = OP_RIGHT;
        case (sym)
            CH_RIGHT: d.op = OP_RIGHT;
            CH_LEFT:  d.op = OP_LEFT;
            CH_INC:   d.op = OP_INC;
            CH_DEC:   d.op = OP_DEC;
            CH_OUT:   d.op = OP_OUT;
            CH_IN:    d.op = OP_IN;
            CH_OPEN:  d.op = OP_OPEN;
            CH_CLOSE: d.op = OP_CLOSE;
            default:  d.is_cmd = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ----- src/tape_language_interpreter_core.sv -----
// Tape language interpreter core.
// Input channel (i_valid / o_stall): each request is either a load of one program
// character (i_kind 0, i_symbol) or one execution step (i_kind 1) that may read
// i_in_valid / i_in_byte / i_in_eof for the ',' command.
// Output channel (o_valid / i_stall): exactly one result per request, in order.
// Program and bracket partners share one program memory; until its close arrives,
// an open bracket's entry links to the open bracket that encloses it. The tape is
// a second memory. Both have registered reads.
// Path: S_WORK loads the result register; a ']' load passes S_WORK, then S_CLOSE,
// which write both partners through the single program write port.
// A new request is taken in the cycle after the result is registered, so
// the core never takes a new request while the last one is in flight.
// A result waiting in the output register does not block the next request;
// if the receiver still stalls when the next result is ready, the core holds
// that result and keeps o_stall high until the output register frees up.
// Reset: after i_rst_n the core sweeps the tape to zero, one cell per cycle,
// all TAPE_DEPTH cells, with o_stall high; then it takes requests.
module tape_language_interpreter_core
    import tli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_symbol,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_eof,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_in_consumed,
    output logic       o_need_input,
    output logic       o_halted,
    output logic [1:0] o_error_code
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WORK  = 3'd2;
    localparam logic [2:0] S_CLOSE = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    localparam logic [PROG_LW-1:0] PROG_FULL = PROG_LW'(PROG_DEPTH);
    localparam logic [NEST_LW-1:0] NEST_FULL = NEST_LW'(NEST_DEPTH);
    localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_DEPTH - 1);

    logic [2:0]         r_state, n_state;
    logic [TAPE_AW-1:0] r_clr, n_clr;
    logic               r_kind, n_kind;
    logic [7:0]         r_symbol, n_symbol;
    logic               r_in_valid, n_in_valid;
    logic [7:0]         r_in_byte, n_in_byte;
    logic               r_in_eof, n_in_eof;
    logic [PROG_LW-1:0] r_len, n_len;
    logic [NEST_LW-1:0] r_level, n_level;
    logic [PROG_AW-1:0] r_top, n_top;
    logic [PROG_LW-1:0] r_pc, n_pc;
    logic [TAPE_AW-1:0] r_head, n_head;
    logic               r_stopped, n_stopped;
    logic [1:0]         r_error, n_error;
    logic [PROG_AW-1:0] r_partner, n_partner;
    t_result            r_res, n_res;

    logic               prog_we;
    logic [PROG_AW-1:0] prog_waddr;
    logic [PROG_EW-1:0] prog_wdata;
    logic [PROG_AW-1:0] prog_raddr;
    logic [PROG_EW-1:0] prog_rdata;
    logic               tape_we;
    logic [TAPE_AW-1:0] tape_waddr;
    logic [7:0]         tape_wdata;
    logic [7:0]         tape_rdata;

    logic [NEST_LW-1:0] w_level_dec;
    t_decode            w_dec;
    logic [2:0]         w_op;
    logic [PROG_LW-1:0] w_jump;
    logic               w_done;
    t_result            w_res;
    logic               out_free;
    logic               out_load;
    t_result            out_data;

    assign w_level_dec = r_level - NEST_LW'(1);
    assign w_dec       = decode_symbol(r_symbol);
    assign w_op        = prog_rdata[PROG_EW-1 -: 3];
    assign w_jump      = PROG_LW'(prog_rdata[PROG_AW-1:0]) + PROG_LW'(1);

    // the read taken at the accept edge serves S_WORK: a step reads its command,
    // a load reads the link stored with the innermost open bracket
    assign prog_raddr = i_kind ? r_pc[PROG_AW-1:0] : r_top;

    tli_ram #(.WIDTH(PROG_EW), .DEPTH(PROG_DEPTH)) u_prog_ram (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (prog_waddr),
        .i_wdata (prog_wdata),
        .i_raddr (prog_raddr),
        .o_rdata (prog_rdata)
    );

    tli_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape_ram (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_raddr (r_head),
        .o_rdata (tape_rdata)
    );

    tli_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_res         (out_data),
        .o_free        (out_free),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_in_consumed (o_in_consumed),
        .o_need_input  (o_need_input),
        .o_halted      (o_halted),
        .o_error_code  (o_error_code)
    );

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_kind     = r_kind;
        n_symbol   = r_symbol;
        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        n_in_eof   = r_in_eof;
        n_len      = r_len;
        n_level    = r_level;
        n_top      = r_top;
        n_pc       = r_pc;
        n_head     = r_head;
        n_stopped  = r_stopped;
        n_error    = r_error;
        n_partner  = r_partner;
        n_res      = r_res;
        prog_we    = 1'b0;
        prog_waddr = r_len[PROG_AW-1:0];
        prog_wdata = {w_dec.op, PROG_AW'(0)};
        tape_we    = 1'b0;
        tape_waddr = r_head;
        tape_wdata = 8'd0;
        w_done     = 1'b0;
        w_res      = '0;

        case (r_state)
            S_CLEAR: begin
                tape_we    = 1'b1;
                tape_waddr = r_clr;
                n_clr      = r_clr + TAPE_AW'(1);
                if (r_clr == TAPE_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_kind     = i_kind;
                    n_symbol   = i_symbol;
                    n_in_valid = i_in_valid;
                    n_in_byte  = i_in_byte;
                    n_in_eof   = i_in_eof;
                    n_state    = S_WORK;
                end
            end
            S_WORK: begin
                w_done = 1'b1;
                if (r_stopped) begin
                    // stopped: report only
                end else if (!r_kind) begin
                    if (!w_dec.is_cmd) begin
                        // drop non-command character
                    end else if (r_len == PROG_FULL) begin
                        n_stopped = 1'b1;
                        n_error   = ERR_FULL;
                    end else if (w_dec.op == OP_OPEN) begin
                        if (r_level == NEST_FULL) begin
                            n_stopped = 1'b1;
                            n_error   = ERR_BRACKET;
                        end else begin
                            // link to the enclosing open bracket until the close arrives
                            prog_we    = 1'b1;
                            prog_wdata = {OP_OPEN, r_top};
                            n_top      = r_len[PROG_AW-1:0];
                            n_level    = r_level + NEST_LW'(1);
                            n_len      = r_len + PROG_LW'(1);
                        end
                    end else if (w_dec.op == OP_CLOSE) begin
                        if (r_level == '0) begin
                            n_stopped = 1'b1;
                            n_error   = ERR_BRACKET;
                        end else begin
                            // point the open bracket at this close; own entry next cycle
                            w_done     = 1'b0;
                            prog_we    = 1'b1;
                            prog_waddr = r_top;
                            prog_wdata = {OP_OPEN, r_len[PROG_AW-1:0]};
                            n_partner  = r_top;
                            n_top      = prog_rdata[PROG_AW-1:0];
                            n_level    = w_level_dec;
                            n_state    = S_CLOSE;
                        end
                    end else begin
                        prog_we = 1'b1;
                        n_len   = r_len + PROG_LW'(1);
                    end
                end else begin
                    if (r_level != '0) begin
                        n_stopped = 1'b1;
                        n_error   = ERR_BRACKET;
                    end else if (r_pc >= r_len) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_pc = r_pc + PROG_LW'(1);
                        case (w_op)
                            OP_RIGHT: begin
                                if (r_head == TAPE_LAST) begin
                                    n_stopped = 1'b1;
                                    n_error   = ERR_TAPE;
                                    n_pc      = r_pc;
                                end else begin
                                    n_head = r_head + TAPE_AW'(1);
                                end
                            end
                            OP_LEFT: begin
                                if (r_head == '0) begin
                                    n_stopped = 1'b1;
                                    n_error   = ERR_TAPE;
                                    n_pc      = r_pc;
                                end else begin
                                    n_head = r_head - TAPE_AW'(1);
                                end
                            end
                            OP_INC: begin
                                tape_we    = 1'b1;
                                tape_wdata = tape_rdata + 8'd1;
                            end
                            OP_DEC: begin
                                tape_we    = 1'b1;
                                tape_wdata = tape_rdata - 8'd1;
                            end
                            OP_OUT: begin
                                w_res.out_valid = 1'b1;
                                w_res.out_byte  = tape_rdata;
                            end
                            OP_IN: begin
                                if (r_in_eof) begin
                                    tape_we           = 1'b1;
                                    tape_wdata        = 8'hFF;
                                    w_res.in_consumed = 1'b1;
                                end else if (r_in_valid) begin
                                    tape_we           = 1'b1;
                                    tape_wdata        = r_in_byte;
                                    w_res.in_consumed = 1'b1;
                                end else begin
                                    // keep the pc on this ',' and report need_input until input shows up
                                    w_res.need_input = 1'b1;
                                    n_pc             = r_pc;
                                end
                            end
                            OP_OPEN: begin
                                if (tape_rdata == 8'd0) begin
                                    n_pc = w_jump;
                                end
                            end
                            OP_CLOSE: begin
                                if (tape_rdata != 8'd0) begin
                                    n_pc = w_jump;
                                end
                            end
                            default: begin
                                n_pc = r_pc;
                            end
                        endcase
                    end
                end
            end
            S_CLOSE: begin
                w_done     = 1'b1;
                prog_we    = 1'b1;
                prog_wdata = {OP_CLOSE, r_partner};
                n_len      = r_len + PROG_LW'(1);
            end
            S_HOLD: begin
                // wait for the output register below
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_res.halted     = n_stopped;
        w_res.error_code = n_error;

        out_load = 1'b0;
        out_data = w_res;
        if (r_state == S_HOLD) begin
            out_data = r_res;
            if (out_free) begin
                out_load = 1'b1;
                n_state  = S_IDLE;
            end
        end else if (w_done) begin
            if (out_free) begin
                out_load = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_res   = w_res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_len     <= '0;
            r_level   <= '0;
            r_top     <= '0;
            r_pc      <= '0;
            r_head    <= '0;
            r_stopped <= 1'b0;
            r_error   <= ERR_NONE;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_len     <= n_len;
            r_level   <= n_level;
            r_top     <= n_top;
            r_pc      <= n_pc;
            r_head    <= n_head;
            r_stopped <= n_stopped;
            r_error   <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_symbol   <= n_symbol;
        r_in_valid <= n_in_valid;
        r_in_byte  <= n_in_byte;
        r_in_eof   <= n_in_eof;
        r_partner  <= n_partner;
        r_res      <= n_res;
    end

endmodule

// ----- src/tli_ram.sv -----
module tli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tli_out_reg.sv -----
module tli_out_reg
    import tli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_res,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_in_consumed,
    output logic       o_need_input,
    output logic       o_halted,
    output logic [1:0] o_error_code
);

    logic    r_valid;
    t_result r_res;

    // slot frees up in the same cycle the receiver takes the result
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_valid   = r_res.out_valid;
    assign o_out_byte    = r_res.out_byte;
    assign o_in_consumed = r_res.in_consumed;
    assign o_need_input  = r_res.need_input;
    assign o_halted      = r_res.halted;
    assign o_error_code  = r_res.error_code;

endmodule
